### hw/rtl/smoothed_fractional_delay_line_defines.svh
// Assertion helpers shared by the delay line modules.
`ifndef SMOOTHED_FRACTIONAL_DELAY_LINE_DEFINES_SVH
`define SMOOTHED_FRACTIONAL_DELAY_LINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFDL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sfdl_pkg.sv
`default_nettype none

package sfdl_pkg;

   localparam int DELAY_DEPTH  = 2048;
   localparam int SAMPLE_WIDTH = 24;
   localparam int ADDR_W       = $clog2(DELAY_DEPTH);
   localparam int FRAC_W       = 12;
   localparam int DELAY_W      = 23;
   localparam int COEFF_W      = 16;
   localparam int POS_W        = ADDR_W + FRAC_W;
   localparam int SPROD_W      = DELAY_W + COEFF_W + 2;
   localparam int IPROD_W      = SAMPLE_WIDTH + FRAC_W + 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = COEFF_W;

   localparam longint DELAY_CAP = longint'(DELAY_DEPTH) * (longint'(1) << FRAC_W) - 1;
   localparam longint POS_SPAN  = longint'(DELAY_DEPTH) * (longint'(1) << FRAC_W);
   localparam longint COEFF_HALF = longint'(1) << (COEFF_W - 1);
   localparam longint FRAC_HALF  = longint'(1) << (FRAC_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_HUMANIZE_ON     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_COEFF = 1'b1;
   localparam logic [COEFF_W-1:0]   COEFF_RESET         = 16'd66;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_in;
      logic signed [SAMPLE_WIDTH-1:0] right_in;
      logic        [DELAY_W-1:0]      target_delay;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic bypass;
      logic smooth_mul;
      logic store_write;
      logic store_read;
      logic interp_sub;
      logic interp_mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SMOOTH = 7'b0000010,
      ST_UPDATE = 7'b0000100,
      ST_FETCH  = 7'b0001000,
      ST_DIFF   = 7'b0010000,
      ST_SCALE  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/sfdl_ctrl.sv
`default_nettype none
`include "smoothed_fractional_delay_line_defines.svh"

module sfdl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             humanize_on,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sfdl_pkg::sts_type sts,
   output sfdl_pkg::cmd_type     cmd
);
   import sfdl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load   = accept;
            cmd.bypass = !humanize_on;
            if (accept) begin
               state_in = humanize_on ? ST_SMOOTH : ST_DONE;
            end
         end
         ST_SMOOTH: begin
            cmd.smooth_mul = 1'b1;
            state_in       = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.store_write = 1'b1;
            state_in        = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.store_read = 1'b1;
            state_in       = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.interp_sub = 1'b1;
            state_in       = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.interp_mul = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFDL_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != ST_IDLE,
                     "An accepted frame did not start the sequence.")
   `SFDL_ASSERT_SAME(a_load_only_when_free, cmd.out_load, sts.out_free,
                     "A result was loaded over one still waiting.")
   `SFDL_ASSERT_NEXT(a_write_then_read, cmd.store_write, cmd.store_read,
                     "The store read did not follow the store write.")

endmodule

`default_nettype wire

### hw/rtl/sfdl_dp.sv
`default_nettype none
`include "smoothed_fractional_delay_line_defines.svh"

module sfdl_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [sfdl_pkg::COEFF_W-1:0]    smoothing_coeff,
   input  wire sfdl_pkg::req_type               req_data,
   input  wire sfdl_pkg::cmd_type               cmd,
   output sfdl_pkg::sts_type                    sts,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output sfdl_pkg::rsp_type                    rsp_data
);
   import sfdl_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   logic signed [SW-1:0] left_mem  [DELAY_DEPTH];
   logic signed [SW-1:0] right_mem [DELAY_DEPTH];

   req_type               req_ff;
   logic                  bypass_ff;
   logic [DELAY_W-1:0]    smoothed_ff, smoothed_in;
   logic [ADDR_W-1:0]     wp_ff, wp_in;
   logic [ADDR_W:0]       filled_ff, filled_in;
   logic signed [SPROD_W-1:0] sprod_ff, sprod_in;

   logic signed [SW-1:0]  la_ff, lb_ff, ra_ff, rb_ff;
   logic                  a_ok_ff, b_ok_ff;
   logic [FRAC_W-1:0]     frac_ff;

   logic signed [SW-1:0]  al_ff, ar_ff;
   logic signed [SW:0]    dl_ff, dr_ff, dl_in, dr_in;
   logic signed [IPROD_W-1:0] ipl_ff, ipr_ff, ipl_in, ipr_in;

   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [DELAY_W:0]   diff_w;
   logic signed [COEFF_W:0]   coeff_s;
   logic signed [SPROD_W-1:0] rnd_s;
   logic [SPROD_W-COEFF_W-1:0] step_w;
   logic [POS_W-1:0]      used_w;
   logic [POS_W:0]        pos_raw;
   logic [POS_W-1:0]      pos_w;
   logic [ADDR_W-1:0]     i0_w, i1_w;
   logic signed [SW-1:0]  la_eff, lb_eff, ra_eff, rb_eff;
   logic signed [FRAC_W:0] frac_s;
   logic signed [IPROD_W-1:0] rndl_w, rndr_w;

   // Smoothing step of the delay.
   assign diff_w   = $signed({1'b0, req_ff.target_delay}) - $signed({1'b0, smoothed_ff});
   assign coeff_s  = $signed({1'b0, smoothing_coeff});
   assign sprod_in = diff_w * coeff_s;
   assign rnd_s    = sprod_ff + SPROD_W'(COEFF_HALF);
   assign step_w   = rnd_s[SPROD_W-1:COEFF_W];
   assign smoothed_in = smoothed_ff + step_w[DELAY_W-1:0];

   // Read position, wrapped round the store.
   assign used_w  = (longint'(smoothed_ff) > DELAY_CAP) ? POS_W'(DELAY_CAP)
                                                        : POS_W'(smoothed_ff);
   assign pos_raw = {1'b0, wp_ff, {FRAC_W{1'b0}}} - {1'b0, used_w};
   assign pos_w   = pos_raw[POS_W] ? POS_W'(pos_raw + (POS_W+1)'(POS_SPAN))
                                   : pos_raw[POS_W-1:0];
   assign i0_w    = pos_w[POS_W-1:FRAC_W];
   assign i1_w    = (i0_w == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : i0_w + 1'b1;

   assign wp_in     = (wp_ff == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign filled_in = (filled_ff == (ADDR_W+1)'(DELAY_DEPTH)) ? filled_ff
                                                              : filled_ff + 1'b1;

   // Entries never written read as zero.
   assign la_eff = a_ok_ff ? la_ff : '0;
   assign lb_eff = b_ok_ff ? lb_ff : '0;
   assign ra_eff = a_ok_ff ? ra_ff : '0;
   assign rb_eff = b_ok_ff ? rb_ff : '0;
   assign dl_in  = {lb_eff[SW-1], lb_eff} - {la_eff[SW-1], la_eff};
   assign dr_in  = {rb_eff[SW-1], rb_eff} - {ra_eff[SW-1], ra_eff};
   assign frac_s = $signed({1'b0, frac_ff});
   assign ipl_in = dl_ff * frac_s;
   assign ipr_in = dr_ff * frac_s;
   assign rndl_w = ipl_ff + IPROD_W'(FRAC_HALF);
   assign rndr_w = ipr_ff + IPROD_W'(FRAC_HALF);

   always_comb begin
      if (bypass_ff) begin
         rsp_in.left_out  = req_ff.left_in;
         rsp_in.right_out = req_ff.right_in;
      end else begin
         rsp_in.left_out  = al_ff + rndl_w[FRAC_W+SW-1:FRAC_W];
         rsp_in.right_out = ar_ff + rndr_w[FRAC_W+SW-1:FRAC_W];
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff  <= '0;
         wp_ff        <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.store_write) begin
            smoothed_ff <= smoothed_in;
            filled_ff   <= filled_in;
         end
         if (cmd.store_read) begin
            wp_ff <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         bypass_ff <= cmd.bypass;
      end
      if (cmd.smooth_mul) begin
         sprod_ff <= sprod_in;
      end
      if (cmd.interp_sub) begin
         al_ff <= la_eff;
         ar_ff <= ra_eff;
         dl_ff <= dl_in;
         dr_ff <= dr_in;
      end
      if (cmd.interp_mul) begin
         ipl_ff <= ipl_in;
         ipr_ff <= ipr_in;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_write) begin
         left_mem[wp_ff]  <= req_ff.left_in;
         right_mem[wp_ff] <= req_ff.right_in;
      end
      if (cmd.store_read) begin
         la_ff   <= left_mem[i0_w];
         lb_ff   <= left_mem[i1_w];
         ra_ff   <= right_mem[i0_w];
         rb_ff   <= right_mem[i1_w];
         a_ok_ff <= ({1'b0, i0_w} < filled_ff);
         b_ok_ff <= ({1'b0, i1_w} < filled_ff);
         frac_ff <= pos_w[FRAC_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SFDL_ASSERT_SAME(a_fill_bound, 1'b1, filled_ff <= (ADDR_W+1)'(DELAY_DEPTH),
                     "The fill count ran past the store depth.")
   `SFDL_ASSERT_NEXT(a_fill_step,
                     cmd.store_write && (filled_ff != (ADDR_W+1)'(DELAY_DEPTH)),
                     filled_ff == $past(filled_ff) + 1'b1,
                     "The fill count did not follow a store write.")
   `SFDL_ASSERT_NEXT(a_position_moves, cmd.store_read, wp_ff != $past(wp_ff),
                     "The write position did not advance after a frame.")

endmodule

`default_nettype wire

### hw/rtl/smoothed_fractional_delay_line.sv
// An enabled frame passes through the smooth, update, fetch, diff, scale and done states, and a
// bypassed frame goes straight to done; the controller takes one frame at a time through its
// sequence, holding off a new frame until the result is loaded, which waits out an output stall.
// The controller sequence is multiply, store write, two-port store read and interpolation.
// Reset clears the controller, the write position, the smoothed delay and the fill count at once;
// store entries not yet written read as zero, so no clearing pass follows reset.
`default_nettype none

module smoothed_fractional_delay_line (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire sfdl_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output sfdl_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_write_en,
   input  wire logic [sfdl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sfdl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sfdl_pkg::*;

   logic               humanize_on_ff;
   logic [COEFF_W-1:0] coeff_ff;
   cmd_type            cmd;
   sts_type            sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         humanize_on_ff <= 1'b0;
         coeff_ff       <= COEFF_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HUMANIZE_ON: begin
               humanize_on_ff <= csr_data[0];
            end
            CSR_SMOOTHING_COEFF: begin
               coeff_ff <= csr_data[COEFF_W-1:0];
            end
            default: begin
               coeff_ff <= coeff_ff;
            end
         endcase
      end
   end

   sfdl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .humanize_on (humanize_on_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   sfdl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .smoothing_coeff (coeff_ff),
      .req_data        (req_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

`default_nettype wire
